// ===== src/necir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types, constants and helpers for the NEC infrared frame decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

    // field widths
    localparam int TICK_W      = 15;
    localparam int STATUS_W    = 2;
    localparam int WORD_W      = 16;
    localparam int SEEN_W      = 7;
    localparam int CFG_INDEX_W = 3;

    // frame layout
    localparam int FULL_FRAME_LEN   = 34;
    localparam int REPEAT_FRAME_LEN = 2;
    localparam int HALF_WORD_BITS   = 16;
    localparam int DATA_BITS        = 2 * HALF_WORD_BITS;
    localparam int BIT_IDX_W        = $clog2(DATA_BITS);

    // default symbol count limit
    localparam int MAX_SYMBOLS_DEF = 64;

    // symbol queue between classifier and frame builder
    localparam int QUEUE_DEPTH = 2;

    // register reset values
    localparam logic [TICK_W-1:0] LEADER_MARK_RST  = TICK_W'(9000);
    localparam logic [TICK_W-1:0] LEADER_SPACE_RST = TICK_W'(4500);
    localparam logic [TICK_W-1:0] BIT_MARK_RST     = TICK_W'(560);
    localparam logic [TICK_W-1:0] ZERO_SPACE_RST   = TICK_W'(560);
    localparam logic [TICK_W-1:0] ONE_SPACE_RST    = TICK_W'(1690);
    localparam logic [TICK_W-1:0] TOLERANCE_RST    = TICK_W'(200);

    // frame status codes
    localparam logic [STATUS_W-1:0] ST_DECODED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REPEAT     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LENGTH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_TIMING = 2'd3;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LEADER_MARK  = 3'd0,
        CFG_LEADER_SPACE = 3'd1,
        CFG_BIT_MARK     = 3'd2,
        CFG_ZERO_SPACE   = 3'd3,
        CFG_ONE_SPACE    = 3'd4,
        CFG_TOLERANCE    = 3'd5
    } t_cfg_index;

    // one captured symbol
    typedef struct packed {
        logic [TICK_W-1:0] mark_ticks;
        logic [TICK_W-1:0] space_ticks;
        logic              last_symbol;
    } t_in_item;

    // one finished frame
    typedef struct packed {
        logic [STATUS_W-1:0] frame_status;
        logic [WORD_W-1:0]   address_word;
        logic [WORD_W-1:0]   command_word;
        logic [SEEN_W-1:0]   symbols_seen;
    } t_out_item;

    // classified symbol as queued for the frame builder
    typedef struct packed {
        logic leader_ok;
        logic one_ok;
        logic zero_ok;
        logic last_symbol;
    } t_sym_class;

    // strict window test, empty when the tolerance exceeds the spec
    function automatic logic within_window(
        input logic [TICK_W-1:0] measured,
        input logic [TICK_W-1:0] spec,
        input logic [TICK_W-1:0] tol
    );
        logic [TICK_W:0] lo;
        logic [TICK_W:0] hi;
        lo = {1'b0, spec} - {1'b0, tol};
        hi = {1'b0, spec} + {1'b0, tol};
        return (tol <= spec) && ({1'b0, measured} > lo) && ({1'b0, measured} < hi);
    endfunction

endpackage

// ===== src/necir_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_front
// Holds the timing registers and classifies each incoming symbol against
// the leader, logic one and logic zero windows.
// ----------------------------------------------------------------------------
module necir_front
    import necir_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [TICK_W-1:0]      i_cfg_data,
    input  logic                   i_in_valid,
    input  t_in_item               i_in_data,
    input  logic                   i_queue_full,
    output logic                   o_in_stall,
    output logic                   o_push,
    output t_sym_class             o_class
);

    logic [TICK_W-1:0] r_leader_mark;
    logic [TICK_W-1:0] r_leader_space;
    logic [TICK_W-1:0] r_bit_mark;
    logic [TICK_W-1:0] r_zero_space;
    logic [TICK_W-1:0] r_one_space;
    logic [TICK_W-1:0] r_tolerance;
    logic              w_mark_ok;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leader_mark  <= LEADER_MARK_RST;
            r_leader_space <= LEADER_SPACE_RST;
            r_bit_mark     <= BIT_MARK_RST;
            r_zero_space   <= ZERO_SPACE_RST;
            r_one_space    <= ONE_SPACE_RST;
            r_tolerance    <= TOLERANCE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_LEADER_MARK:  r_leader_mark  <= i_cfg_data;
                CFG_LEADER_SPACE: r_leader_space <= i_cfg_data;
                CFG_BIT_MARK:     r_bit_mark     <= i_cfg_data;
                CFG_ZERO_SPACE:   r_zero_space   <= i_cfg_data;
                CFG_ONE_SPACE:    r_one_space    <= i_cfg_data;
                CFG_TOLERANCE:    r_tolerance    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // window checks on the incoming symbol
    assign w_mark_ok = within_window(i_in_data.mark_ticks, r_bit_mark, r_tolerance);

    always_comb begin
        o_class.leader_ok =
            within_window(i_in_data.mark_ticks, r_leader_mark, r_tolerance) &&
            within_window(i_in_data.space_ticks, r_leader_space, r_tolerance);
        o_class.one_ok  = w_mark_ok &&
            within_window(i_in_data.space_ticks, r_one_space, r_tolerance);
        o_class.zero_ok = w_mark_ok &&
            within_window(i_in_data.space_ticks, r_zero_space, r_tolerance);
        o_class.last_symbol = i_in_data.last_symbol;
    end

    // accept whenever the queue has room
    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

endmodule

// ===== src/necir_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_queue
// Short queue of classified symbols between the classifier and the frame
// builder; a push and a pop may share a cycle.
// ----------------------------------------------------------------------------
module necir_queue
    import necir_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_sym_class i_push_data,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_not_empty,
    output t_sym_class o_head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_sym_class        r_entry [QUEUE_DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;

    assign o_full      = (r_count == CW'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_entry[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("symbol queue count exceeds depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty symbol queue");
`endif

endmodule

// ===== src/necir_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_back
// Frame builder: counts symbols, gathers the data bits and timing errors,
// and presents one result per frame in an output register.
// ----------------------------------------------------------------------------
module necir_back
    import necir_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_not_empty,
    input  t_sym_class i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data
);

    localparam int CNT_BITS = $clog2(MAX_SYMBOLS + 1);
    localparam int CW       = (CNT_BITS > SEEN_W) ? CNT_BITS : SEEN_W;

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [DATA_BITS-1:0] r_bits;
    logic [DATA_BITS-1:0] n_bits;
    logic                 r_err;
    logic                 n_err;
    logic                 r_out_valid;
    t_out_item            r_out;
    t_out_item            n_out;
    logic [BIT_IDX_W-1:0] w_bit_idx;
    logic                 w_is_data;
    logic                 w_out_free;

    assign w_bit_idx = BIT_IDX_W'(r_count - CW'(1));
    assign w_is_data = (r_count != '0) && (r_count <= CW'(DATA_BITS));

    // a frame's last symbol needs a free output register
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_pop      = i_not_empty && (!i_head.last_symbol || w_out_free);

    // symbol update
    always_comb begin
        n_count = r_count;
        n_bits  = r_bits;
        n_err   = r_err;
        if (r_count == '0) begin
            if (!i_head.leader_ok) begin
                n_err = 1'b1;
            end
        end else if (w_is_data) begin
            if (i_head.one_ok) begin
                n_bits[w_bit_idx] = 1'b1;
            end else if (!i_head.zero_ok) begin
                n_err = 1'b1;
            end
        end
        if (r_count < CW'(MAX_SYMBOLS)) begin
            n_count = r_count + CW'(1);
        end
    end

    // frame result
    always_comb begin
        n_out.address_word = '0;
        n_out.command_word = '0;
        n_out.symbols_seen = n_count[SEEN_W-1:0];
        if (n_count == CW'(FULL_FRAME_LEN)) begin
            if (n_err) begin
                n_out.frame_status = ST_BAD_TIMING;
            end else begin
                n_out.frame_status = ST_DECODED;
                n_out.address_word = n_bits[HALF_WORD_BITS-1:0];
                n_out.command_word = n_bits[DATA_BITS-1:HALF_WORD_BITS];
            end
        end else if (n_count == CW'(REPEAT_FRAME_LEN)) begin
            n_out.frame_status = ST_REPEAT;
        end else begin
            n_out.frame_status = ST_BAD_LENGTH;
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bits  <= '0;
            r_err   <= 1'b0;
        end else if (o_pop) begin
            if (i_head.last_symbol) begin
                r_count <= '0;
                r_bits  <= '0;
                r_err   <= 1'b0;
            end else begin
                r_count <= n_count;
                r_bits  <= n_bits;
                r_err   <= n_err;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_head.last_symbol) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last_symbol) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SYMBOLS))
        else $error("symbol count passed its limit");

    a_decoded_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.frame_status == ST_DECODED)) |->
            (r_out.symbols_seen == SEEN_W'(FULL_FRAME_LEN)))
        else $error("decoded frame with wrong symbol count");

    a_repeat_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.frame_status == ST_REPEAT)) |->
            ((r_out.symbols_seen == SEEN_W'(REPEAT_FRAME_LEN)) &&
             (r_out.address_word == '0) && (r_out.command_word == '0)))
        else $error("repeat frame with wrong count or data");
`endif

endmodule

// ===== src/nec_ir_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// Decodes NEC infrared frames from captured mark/space symbols.
// ----------------------------------------------------------------------------
// Input channel: one symbol per transaction (mark and space in ticks plus a
// last-symbol flag), taken when i_in_valid is high and o_in_stall is low.
// Output channel: one frame result per frame, on the transaction carrying the
// last symbol; held in o_out_data while o_out_valid is high and i_out_stall
// is high.
// Configuration: write i_cfg_data to register i_cfg_index when i_cfg_we is
// high; only while no frame is in flight. Indexes above 5 are ignored.
// Throughput: one symbol per cycle while o_in_stall is low. The window checks
// are done as the symbol arrives; the classified symbol goes into a two-entry
// queue, and the frame builder takes one entry per cycle but holds a frame's
// last symbol while the output register is valid and stalled. Each symbol
// is queued when taken; the result loads when the last one is popped.
// Receiver stall: the frame builder keeps taking symbols of the next frame
// until it reaches that frame's last symbol; then the queue fills and
// o_in_stall rises.
// Reset: timing registers return to their defaults, the frame state and the
// queue are emptied and o_out_valid drops.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder
    import necir_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [TICK_W-1:0]      i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_data
);

    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_not_empty;
    t_sym_class w_class;
    t_sym_class w_head;

    // symbol classifier
    necir_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_queue_full (w_full),
        .o_in_stall   (o_in_stall),
        .o_push       (w_push),
        .o_class      (w_class)
    );

    // classified symbol queue
    necir_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_class),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_not_empty (w_not_empty),
        .o_head      (w_head)
    );

    // frame builder and result register
    necir_back #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_not_empty (w_not_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
